// ----- hdl/dpa_pkg.sv -----
// ----------------------------------------------------------------------------
// dpa_pkg
// Shared types and constants for the demand paging page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package dpa_pkg;

	// defaults for the top level parameters
	localparam int PHYS_PAGES_DEF = 1024;
	localparam int VADDR_BITS_DEF = 48;

	// fixed field widths
	localparam int VA_W       = 48;
	localparam int SIZE_W     = 32;
	localparam int FREE_W     = 11;
	localparam int LG_W       = 5;
	localparam int CNT_REG_W  = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// page size limits
	localparam int LG_MIN = 6;
	localparam int LG_MAX = 30;

	// internal widths sized for the widest parameter values
	localparam int WIDE_W    = 64;
	localparam int VPN_MAX_W = WIDE_W - LG_MIN;
	localparam int OFF_W     = LG_MAX;
	localparam int NP_W      = SIZE_W + 1 - LG_MIN;
	localparam int EFF_CNT_W = 17;

	// defaults after reset
	localparam logic [LG_W-1:0]      LG_RST  = LG_W'(12);
	localparam logic [CNT_REG_W-1:0] CNT_RST = CNT_REG_W'(1024);

	// request codes
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_TRANS = 1'b1;

	// work queue depth
	localparam int QDEPTH = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_XLATE_EN   = 2'd0,
		CFG_PAGE_LOG2  = 2'd1,
		CFG_PAGE_COUNT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		JOB_ALLOC,
		JOB_PASS,
		JOB_TRANS
	} job_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APAGE,
		ST_SRD,
		ST_SCMP,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic              req_type;
		logic [VA_W-1:0]   virt_addr;
		logic [SIZE_W-1:0] alloc_size;
	} in_t;

	typedef struct packed {
		logic [VA_W-1:0]   phys_addr;
		logic              status;
		logic              found_mapping;
		logic [FREE_W-1:0] free_pages_left;
	} out_t;

	// classified work for the back end
	typedef struct packed {
		job_kind_t            kind;
		logic [VA_W-1:0]      va;
		logic [VPN_MAX_W-1:0] vpn;
		logic [OFF_W-1:0]     offset;
		logic [NP_W-1:0]      npages;
	} job_t;

	// effective configuration
	typedef struct packed {
		logic                 xlate_en;
		logic [LG_W-1:0]      lg;
		logic [EFF_CNT_W-1:0] cnt;
	} cfg_t;

endpackage

`default_nettype wire

// ----- hdl/dpa_front.sv -----
// ----------------------------------------------------------------------------
// dpa_front
// Accepts request words, masks the address and splits it into page number,
// offset and page count, then pushes the classified job into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_front #(
	parameter int VADDR_BITS = dpa_pkg::VADDR_BITS_DEF
) (
	input  wire              in_valid,
	output logic             in_ready,
	input  dpa_pkg::in_t     in_data,
	input  dpa_pkg::cfg_t    cfg,
	input  wire              q_full,
	output logic             push,
	output dpa_pkg::job_t    job
);

	localparam logic [dpa_pkg::WIDE_W-1:0] VMASK =
		(dpa_pkg::WIDE_W'(1) << VADDR_BITS) - dpa_pkg::WIDE_W'(1);

	logic [dpa_pkg::WIDE_W-1:0] va_m;
	logic [dpa_pkg::WIDE_W-1:0] vpn_w;
	logic [dpa_pkg::WIDE_W-1:0] off_w;
	logic [dpa_pkg::SIZE_W:0]   size_r;
	logic [dpa_pkg::SIZE_W:0]   np_w;

	// handshake toward the queue
	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	// address split and page count round up
	always_comb begin
		va_m   = dpa_pkg::WIDE_W'(in_data.virt_addr) & VMASK;
		vpn_w  = va_m >> cfg.lg;
		off_w  = va_m & ((dpa_pkg::WIDE_W'(1) << cfg.lg) - dpa_pkg::WIDE_W'(1));
		size_r = (dpa_pkg::SIZE_W+1)'(in_data.alloc_size)
			+ (((dpa_pkg::SIZE_W+1)'(1) << cfg.lg) - (dpa_pkg::SIZE_W+1)'(1));
		np_w   = size_r >> cfg.lg;

		if (in_data.req_type == dpa_pkg::REQ_ALLOC) begin
			job.kind = dpa_pkg::JOB_ALLOC;
		end else if (cfg.xlate_en) begin
			job.kind = dpa_pkg::JOB_TRANS;
		end else begin
			job.kind = dpa_pkg::JOB_PASS;
		end
		job.va     = va_m[dpa_pkg::VA_W-1:0];
		job.vpn    = vpn_w[dpa_pkg::VPN_MAX_W-1:0];
		job.offset = off_w[dpa_pkg::OFF_W-1:0];
		job.npages = np_w[dpa_pkg::NP_W-1:0];
	end

endmodule

`default_nettype wire

// ----- hdl/dpa_queue.sv -----
// ----------------------------------------------------------------------------
// dpa_queue
// Short job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  dpa_pkg::job_t   push_data,
	input  wire             pop,
	output logic            full,
	output logic            not_empty,
	output dpa_pkg::job_t   head
);

	localparam int PTR_W = (dpa_pkg::QDEPTH > 1) ? $clog2(dpa_pkg::QDEPTH) : 1;
	localparam int CNT_W = $clog2(dpa_pkg::QDEPTH + 1);

	dpa_pkg::job_t     store_q [dpa_pkg::QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = (cnt_q == CNT_W'(dpa_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = store_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(dpa_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(dpa_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// job storage
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- hdl/dpa_back.sv -----
// ----------------------------------------------------------------------------
// dpa_back
// Carries out jobs: linear page table search, page allocation from the free
// counter, entry writes and the result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpa_back #(
	parameter int PHYS_PAGES = dpa_pkg::PHYS_PAGES_DEF,
	parameter int VADDR_BITS = dpa_pkg::VADDR_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             q_valid,
	input  dpa_pkg::job_t   head,
	output logic            pop,
	input  dpa_pkg::cfg_t   cfg,
	output logic            out_valid,
	input  wire             out_ready,
	output dpa_pkg::out_t   out_data
);

	localparam int PI_W  = (PHYS_PAGES > 1) ? $clog2(PHYS_PAGES) : 1;
	localparam int CNT_W = $clog2(PHYS_PAGES + 1);
	localparam int VPN_W = VADDR_BITS - dpa_pkg::LG_MIN;
	localparam int ENT_W = VPN_W + PI_W;

	dpa_pkg::state_t      state_q, state_nxt;
	dpa_pkg::job_kind_t   kind_q;
	logic [VPN_W-1:0]     vpn_q;
	logic [dpa_pkg::OFF_W-1:0] off_q;
	logic [dpa_pkg::NP_W-1:0]  left_q;
	logic [PI_W-1:0]      ppn_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     next_free_q;
	logic [CNT_W-1:0]     ent_cnt_q;
	logic                 status_q;
	logic                 found_q;
	logic [dpa_pkg::VA_W-1:0] phys_q;
	logic                 out_valid_q;
	dpa_pkg::out_t        out_data_q;

	logic [ENT_W-1:0]     mem [PHYS_PAGES];
	logic [ENT_W-1:0]     rdata_q;

	logic [CNT_W-1:0]     cnt_eff;
	logic                 free_ok;
	logic                 tbl_end;
	logic                 hit;
	logic                 last_page;
	logic [VPN_W-1:0]     pmask;
	logic [VPN_W-1:0]     vpn_inc;
	logic [PI_W-1:0]      phys_ppn;
	logic [dpa_pkg::VA_W-1:0] phys_calc;
	logic [dpa_pkg::EFF_CNT_W-1:0] free_left;
	logic                 mem_re;
	logic                 mem_we;
	logic [PI_W-1:0]      wr_ppn;
	logic                 out_load;

	// status shared by next state and outputs
	always_comb begin
		cnt_eff   = cfg.cnt[CNT_W-1:0];
		free_ok   = next_free_q < cnt_eff;
		tbl_end   = idx_q == ent_cnt_q;
		hit       = rdata_q[ENT_W-1:PI_W] == vpn_q;
		last_page = left_q == dpa_pkg::NP_W'(1);
		pmask     = {VPN_W{1'b1}} >> (cfg.lg - dpa_pkg::LG_W'(dpa_pkg::LG_MIN));
		vpn_inc   = (vpn_q + 1'b1) & pmask;
		phys_ppn  = (state_q == dpa_pkg::ST_APAGE) ? next_free_q[PI_W-1:0]
			: rdata_q[PI_W-1:0];
		phys_calc = (dpa_pkg::VA_W'(phys_ppn) << cfg.lg) + dpa_pkg::VA_W'(off_q);
		free_left = (cfg.cnt > dpa_pkg::EFF_CNT_W'(next_free_q))
			? cfg.cnt - dpa_pkg::EFF_CNT_W'(next_free_q) : '0;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			dpa_pkg::ST_IDLE: begin
				if (q_valid) begin
					case (head.kind)
						dpa_pkg::JOB_ALLOC: state_nxt = (head.npages == '0)
							? dpa_pkg::ST_FIN : dpa_pkg::ST_APAGE;
						dpa_pkg::JOB_TRANS: state_nxt = dpa_pkg::ST_SRD;
						default:            state_nxt = dpa_pkg::ST_FIN;
					endcase
				end
			end
			dpa_pkg::ST_APAGE: begin
				if (!free_ok || kind_q == dpa_pkg::JOB_TRANS) begin
					state_nxt = dpa_pkg::ST_FIN;
				end else begin
					state_nxt = dpa_pkg::ST_SRD;
				end
			end
			dpa_pkg::ST_SRD: begin
				if (!tbl_end) begin
					state_nxt = dpa_pkg::ST_SCMP;
				end else if (kind_q == dpa_pkg::JOB_TRANS || !last_page) begin
					state_nxt = dpa_pkg::ST_APAGE;
				end else begin
					state_nxt = dpa_pkg::ST_FIN;
				end
			end
			dpa_pkg::ST_SCMP: begin
				if (!hit) begin
					state_nxt = dpa_pkg::ST_SRD;
				end else if (kind_q == dpa_pkg::JOB_TRANS || last_page) begin
					state_nxt = dpa_pkg::ST_FIN;
				end else begin
					state_nxt = dpa_pkg::ST_APAGE;
				end
			end
			dpa_pkg::ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					state_nxt = dpa_pkg::ST_IDLE;
				end
			end
			default: state_nxt = dpa_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop      = 1'b0;
		mem_re   = 1'b0;
		mem_we   = 1'b0;
		wr_ppn   = ppn_q;
		out_load = 1'b0;
		case (state_q)
			dpa_pkg::ST_IDLE:  pop = q_valid;
			dpa_pkg::ST_APAGE: begin
				mem_we = free_ok && kind_q == dpa_pkg::JOB_TRANS;
				wr_ppn = next_free_q[PI_W-1:0];
			end
			dpa_pkg::ST_SRD: begin
				mem_re = !tbl_end;
				mem_we = tbl_end && kind_q == dpa_pkg::JOB_ALLOC;
			end
			dpa_pkg::ST_FIN:   out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpa_pkg::ST_IDLE;
			next_free_q <= '0;
			ent_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == dpa_pkg::ST_APAGE && free_ok) begin
				next_free_q <= next_free_q + 1'b1;
			end
			if (mem_we) begin
				ent_cnt_q <= ent_cnt_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// job datapath
	always_ff @(posedge clk) begin
		case (state_q)
			dpa_pkg::ST_IDLE: begin
				if (q_valid) begin
					kind_q   <= head.kind;
					vpn_q    <= head.vpn[VPN_W-1:0];
					off_q    <= head.offset;
					left_q   <= head.npages;
					idx_q    <= '0;
					status_q <= 1'b0;
					found_q  <= 1'b0;
					phys_q   <= (head.kind == dpa_pkg::JOB_PASS) ? head.va : '0;
				end
			end
			dpa_pkg::ST_APAGE: begin
				idx_q <= '0;
				if (!free_ok) begin
					status_q <= 1'b1;
				end else begin
					ppn_q <= next_free_q[PI_W-1:0];
					if (kind_q == dpa_pkg::JOB_TRANS) begin
						phys_q <= phys_calc;
					end
				end
			end
			dpa_pkg::ST_SRD: begin
				if (tbl_end && kind_q == dpa_pkg::JOB_ALLOC) begin
					vpn_q  <= vpn_inc;
					left_q <= left_q - 1'b1;
				end
			end
			dpa_pkg::ST_SCMP: begin
				if (!hit) begin
					idx_q <= idx_q + 1'b1;
				end else if (kind_q == dpa_pkg::JOB_TRANS) begin
					found_q <= 1'b1;
					phys_q  <= phys_calc;
				end else begin
					vpn_q  <= vpn_inc;
					left_q <= left_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// page table memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ent_cnt_q[PI_W-1:0]] <= {vpn_q, wr_ppn};
		end
		if (mem_re) begin
			rdata_q <= mem[idx_q[PI_W-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.phys_addr       <= phys_q;
			out_data_q.status          <= status_q;
			out_data_q.found_mapping   <= found_q;
			out_data_q.free_pages_left <= free_left[dpa_pkg::FREE_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ----- hdl/demand_paging_page_allocator.sv -----
// ----------------------------------------------------------------------------
// demand_paging_page_allocator
// Page table with demand page allocation from a linear free counter.
//
//   port group   dir   handshake          contents
//   in_*         in    in_valid/in_ready  req_type, virt_addr, alloc_size
//   out_*        out   out_valid/out_ready phys_addr, status, found_mapping,
//                                          free_pages_left
//   cfg_*        in    cfg_we             cfg_index, cfg_data
//
// The page table is one memory searched one entry at a time (read, then
// compare). An allocate takes, per page, a free page and then a search of
// the table.
// A two-word queue lets the front accept while the back end works, and the
// output register holds a result while the next job runs. Reset clears the
// free counter and the entry count; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_paging_page_allocator #(
	parameter int PHYS_PAGES = dpa_pkg::PHYS_PAGES_DEF,
	parameter int VADDR_BITS = dpa_pkg::VADDR_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  dpa_pkg::in_t                     in_data,
	output logic                             out_valid,
	input  wire                              out_ready,
	output dpa_pkg::out_t                    out_data,
	input  wire                              cfg_we,
	input  wire [dpa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire [dpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic                          xlate_en_q;
	logic [dpa_pkg::LG_W-1:0]      lg_q;
	logic [dpa_pkg::CNT_REG_W-1:0] cnt_q;
	dpa_pkg::cfg_t                 cfg;
	logic                          q_full;
	logic                          q_not_empty;
	logic                          push;
	logic                          pop;
	dpa_pkg::job_t                 job;
	dpa_pkg::job_t                 head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xlate_en_q <= 1'b1;
			lg_q       <= dpa_pkg::LG_RST;
			cnt_q      <= dpa_pkg::CNT_RST;
		end else if (cfg_we) begin
			case (dpa_pkg::cfg_idx_t'(cfg_index))
				dpa_pkg::CFG_XLATE_EN:   xlate_en_q <= cfg_data[0];
				dpa_pkg::CFG_PAGE_LOG2:  lg_q       <= cfg_data[dpa_pkg::LG_W-1:0];
				dpa_pkg::CFG_PAGE_COUNT: cnt_q      <= cfg_data[dpa_pkg::CNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp to effective values
	always_comb begin
		cfg.xlate_en = xlate_en_q;
		if (lg_q < dpa_pkg::LG_W'(dpa_pkg::LG_MIN)) begin
			cfg.lg = dpa_pkg::LG_W'(dpa_pkg::LG_MIN);
		end else if (lg_q > dpa_pkg::LG_W'(dpa_pkg::LG_MAX)) begin
			cfg.lg = dpa_pkg::LG_W'(dpa_pkg::LG_MAX);
		end else begin
			cfg.lg = lg_q;
		end
		if (32'(cnt_q) > 32'(PHYS_PAGES)) begin
			cfg.cnt = dpa_pkg::EFF_CNT_W'(PHYS_PAGES);
		end else begin
			cfg.cnt = dpa_pkg::EFF_CNT_W'(cnt_q);
		end
	end

	dpa_front #(
		.VADDR_BITS (VADDR_BITS)
	) u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.job      (job)
	);

	dpa_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head)
	);

	dpa_back #(
		.PHYS_PAGES (PHYS_PAGES),
		.VADDR_BITS (VADDR_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_not_empty),
		.head      (head),
		.pop       (pop),
		.cfg       (cfg),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ----- verif/demand_paging_page_allocator_tb.sv -----
// ----------------------------------------------------------------------------
// demand_paging_page_allocator_tb
// Self-checking bench for the page allocator. A scoreboard class mirrors the
// page table, the free counter and the settings, predicts one result word per
// request and compares results in order. Runs through several page sizes,
// page counts and the pass-through mode with random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

class page_table_scoreboard;
	bit                              xlate_en;
	bit [dpa_pkg::LG_W-1:0]          lg_reg;
	bit [dpa_pkg::CNT_REG_W-1:0]     count_reg;
	int                              next_free;
	int                              entries;
	longint unsigned                 vpage_tab[1024];
	int                              ppage_tab[1024];
	dpa_pkg::out_t                   expected_q[$];
	int                              errors;

	function new();
		xlate_en  = 1'b1;
		lg_reg    = dpa_pkg::LG_RST;
		count_reg = dpa_pkg::CNT_RST;
		next_free = 0;
		entries   = 0;
		errors    = 0;
	endfunction

	function void set_reg(dpa_pkg::cfg_idx_t idx, bit [dpa_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			dpa_pkg::CFG_XLATE_EN:   xlate_en = val[0];
			dpa_pkg::CFG_PAGE_LOG2:  lg_reg = val[dpa_pkg::LG_W-1:0];
			dpa_pkg::CFG_PAGE_COUNT: count_reg = val[dpa_pkg::CNT_REG_W-1:0];
			default: ;
		endcase
	endfunction

	function int page_log2();
		if (int'(lg_reg) < dpa_pkg::LG_MIN) return dpa_pkg::LG_MIN;
		if (int'(lg_reg) > dpa_pkg::LG_MAX) return dpa_pkg::LG_MAX;
		return int'(lg_reg);
	endfunction

	function int usable_pages();
		return (int'(count_reg) > dpa_pkg::PHYS_PAGES_DEF) ? dpa_pkg::PHYS_PAGES_DEF
			: int'(count_reg);
	endfunction

	function int pages_free();
		return (usable_pages() > next_free) ? usable_pages() - next_free : 0;
	endfunction

	function int find_page(longint unsigned vp);
		for (int i = 0; i < entries; i++)
			if (vpage_tab[i] == vp) return i;
		return -1;
	endfunction

	// map np pages from vp on, returns 1 when free pages run out
	function bit map_pages(longint unsigned vp, longint unsigned np, int lg);
		longint unsigned pmask;
		longint unsigned cur;
		pmask = (64'd1 << (dpa_pkg::VA_W - lg)) - 64'd1;
		for (longint unsigned i = 0; i < np; i++) begin
			cur = (vp + i) & pmask;
			if (next_free >= usable_pages()) return 1'b1;
			if (find_page(cur) < 0 && entries < 1024) begin
				vpage_tab[entries] = cur;
				ppage_tab[entries] = next_free;
				entries++;
			end
			next_free++;
		end
		return 1'b0;
	endfunction

	// predict the result word of an accepted request
	function void note_request(dpa_pkg::in_t req);
		int              lg;
		int              e;
		longint unsigned va, vp, off, np, phys;
		dpa_pkg::out_t   res;
		lg   = page_log2();
		va   = 64'(req.virt_addr);
		vp   = va >> lg;
		off  = va & ((64'd1 << lg) - 64'd1);
		phys = 0;
		res  = '0;
		if (req.req_type == dpa_pkg::REQ_ALLOC) begin
			np = ({32'd0, req.alloc_size} + (64'd1 << lg) - 64'd1) >> lg;
			res.status = map_pages(vp, np, lg);
		end else if (!xlate_en) begin
			phys = va;
		end else begin
			e = find_page(vp);
			if (e >= 0) begin
				res.found_mapping = 1'b1;
			end else begin
				res.status = map_pages(vp, 1, lg);
				if (!res.status) e = find_page(vp);
			end
			if (e >= 0) phys = (longint'(ppage_tab[e]) << lg) + off;
		end
		res.phys_addr       = phys[dpa_pkg::VA_W-1:0];
		res.free_pages_left = dpa_pkg::FREE_W'(pages_free());
		expected_q.push_back(res);
	endfunction

	// compare a result word with the oldest prediction
	function void check_result(dpa_pkg::out_t got);
		dpa_pkg::out_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result word %h", $time, got);
			errors++;
			return;
		end
		want = expected_q[0];
		expected_q.delete(0);
		if (got.phys_addr !== want.phys_addr) begin
			$display("%0t: phys_addr exp %h got %h", $time, want.phys_addr, got.phys_addr);
			errors++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status exp %b got %b", $time, want.status, got.status);
			errors++;
		end
		if (got.found_mapping !== want.found_mapping) begin
			$display("%0t: found_mapping exp %b got %b", $time,
				want.found_mapping, got.found_mapping);
			errors++;
		end
		if (got.free_pages_left !== want.free_pages_left) begin
			$display("%0t: free_pages_left exp %0d got %0d", $time,
				want.free_pages_left, got.free_pages_left);
			errors++;
		end
	endfunction
endclass

module demand_paging_page_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                           clk;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	dpa_pkg::in_t                   in_data;
	logic                           out_valid;
	logic                           out_ready;
	dpa_pkg::out_t                  out_data;
	logic                           cfg_we;
	logic [dpa_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [dpa_pkg::CFG_DATA_W-1:0] cfg_data;

	page_table_scoreboard           sb;
	bit                             no_gaps;
	logic [dpa_pkg::VA_W-1:0]       addr_pool[$];

	demand_paging_page_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop
	initial begin
		#(12 * 30_000_000);
		$display("[FAIL] regression broken");
		$finish;
	end

	// result side with random stalls per word
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = no_gaps ? 0 : $urandom_range(0, 10);
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(out_data);
		end
	end

	task automatic write_reg(dpa_pkg::cfg_idx_t idx, int val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = dpa_pkg::CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we    = 1'b0;
		sb.set_reg(idx, dpa_pkg::CFG_DATA_W'(val));
	endtask

	task automatic send_word(logic rt, logic [dpa_pkg::VA_W-1:0] va,
			logic [dpa_pkg::SIZE_W-1:0] sz);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data.req_type   = rt;
		in_data.virt_addr  = va;
		in_data.alloc_size = sz;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_request(in_data);
		if (rt == dpa_pkg::REQ_ALLOC || addr_pool.size() < 64) addr_pool.push_back(va);
		@(negedge clk);
	endtask

	// wait until every predicted word has come back
	task automatic drain();
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// random request, mostly allocs of a few pages and lookups of known pages
	task automatic random_request();
		int                          lg;
		logic [dpa_pkg::VA_W-1:0]    va;
		logic [dpa_pkg::SIZE_W-1:0]  sz;
		longint unsigned             span;
		lg = sb.page_log2();
		va = dpa_pkg::VA_W'({$urandom, $urandom});
		if (addr_pool.size() != 0 && $urandom_range(0, 9) < 6)
			va = dpa_pkg::VA_W'(64'(addr_pool[$urandom_range(0, addr_pool.size() - 1)]) ^
				(64'($urandom) & ((64'd1 << lg) - 64'd1)));
		if ($urandom_range(0, 1) == 0) begin
			span = 64'd4 << lg;
			if (lg >= 30 || sb.pages_free() <= 8 || $urandom_range(0, 19) == 0)
				sz = $urandom;
			else
				sz = $urandom_range(0,
					32'((span > 64'h0_FFFF_FFFF) ? 64'h0_FFFF_FFFF : span));
			if (lg < 20 && sb.pages_free() > 8) sz = sz & 32'h000F_FFFF;
			send_word(dpa_pkg::REQ_ALLOC, va, sz);
		end else begin
			send_word(dpa_pkg::REQ_TRANS, va, $urandom);
		end
	endtask

	task automatic random_phase(int n);
		no_gaps = ($urandom_range(0, 3) == 0);
		repeat (n) random_request();
		no_gaps = 1'b0;
		drain();
	endtask

	initial begin
		sb        = new();
		no_gaps   = 1'b0;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty alloc, remap, hits, misses, wrap at the top
		write_reg(dpa_pkg::CFG_XLATE_EN, 1);
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 12);
		write_reg(dpa_pkg::CFG_PAGE_COUNT, 1024);
		send_word(dpa_pkg::REQ_ALLOC, 48'h0, 32'h0);
		send_word(dpa_pkg::REQ_ALLOC, 48'h1234, 32'h1);
		send_word(dpa_pkg::REQ_ALLOC, 48'h1000, 32'h2000);
		send_word(dpa_pkg::REQ_TRANS, 48'h1ABC, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'h2FFF, 32'hFFFF_FFFF);
		send_word(dpa_pkg::REQ_TRANS, 48'h5_0123, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'h5_0FFF, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'hFFFF_FFFF_FFFF, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'hFFFF_FFFF_F000, 32'h0);
		send_word(dpa_pkg::REQ_ALLOC, 48'hFFFF_FFFF_E800, 32'h3000);
		send_word(dpa_pkg::REQ_TRANS, 48'h0, 32'h0);
		send_word(dpa_pkg::REQ_ALLOC, 48'h7000, 32'h1001);
		send_word(dpa_pkg::REQ_TRANS, 48'h8008, 32'h0);
		drain();
		// pass through mode
		write_reg(dpa_pkg::CFG_XLATE_EN, 0);
		send_word(dpa_pkg::REQ_TRANS, 48'hFFFF_FFFF_FFFF, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'h0, 32'h0);
		send_word(dpa_pkg::REQ_TRANS, 48'h1ABC, 32'h0);
		send_word(dpa_pkg::REQ_ALLOC, 48'h40_0000, 32'h1000);
		drain();
		write_reg(dpa_pkg::CFG_XLATE_EN, 1);
		send_word(dpa_pkg::REQ_TRANS, 48'h40_0010, 32'h0);
		drain();

		// smallest pages
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 6);
		random_phase(90);
		// largest pages, pass through then translating
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 30);
		write_reg(dpa_pkg::CFG_XLATE_EN, 0);
		random_phase(50);
		write_reg(dpa_pkg::CFG_XLATE_EN, 1);
		random_phase(60);
		// out of range page sizes clamp
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 31);
		random_phase(20);
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 0);
		random_phase(20);
		// no pages at all, then a single page, then above the physical limit
		write_reg(dpa_pkg::CFG_PAGE_COUNT, 0);
		random_phase(25);
		write_reg(dpa_pkg::CFG_PAGE_COUNT, 1);
		random_phase(20);
		write_reg(dpa_pkg::CFG_PAGE_COUNT, 2047);
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 16);
		random_phase(80);
		write_reg(dpa_pkg::CFG_PAGE_LOG2, $urandom_range(7, 29));
		random_phase(80);
		write_reg(dpa_pkg::CFG_PAGE_COUNT, 1024);
		write_reg(dpa_pkg::CFG_PAGE_LOG2, 12);
		random_phase(60);

		drain();
		repeat (100) @(negedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

`default_nettype wire

// ----- sim.f -----
hdl/dpa_pkg.sv
hdl/dpa_front.sv
hdl/dpa_queue.sv
hdl/dpa_back.sv
hdl/demand_paging_page_allocator.sv
verif/demand_paging_page_allocator_tb.sv
